// ===== src/gidi_pkg.sv =====
// ----------------------------------------------------------------------------
// gidi_pkg
// Types and constants shared by the grid inverse distance interpolator.
// ----------------------------------------------------------------------------
package gidi_pkg;

  localparam int X_CELLS_DEF = 200;
  localparam int Y_CELLS_DEF = 24;
  localparam int Z_CELLS_DEF = 14;

  localparam logic signed [31:0] X_ORIGIN_RST  = -32'sd6553600;
  localparam logic signed [31:0] Y_ORIGIN_RST  = 32'sd21168128;
  localparam logic signed [31:0] Z_ORIGIN_RST  = 32'sd22282;
  localparam logic [30:0]        X_SPACING_RST = 31'd65536;
  localparam logic [30:0]        Y_SPACING_RST = 31'd65536;
  localparam logic [30:0]        Z_SPACING_RST = 31'd655;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int VAL_W      = 16;
  localparam int CORNER_W   = 3 * VAL_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_ORIGIN  = 3'd0,
    CFG_Y_ORIGIN  = 3'd1,
    CFG_Z_ORIGIN  = 3'd2,
    CFG_X_SPACING = 3'd3,
    CFG_Y_SPACING = 3'd4,
    CFG_Z_SPACING = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOC_START,
    S_LOC_DIV,
    S_LOC_FIX,
    S_ADDR0,
    S_ADDR1,
    S_OFF_MUL,
    S_OFF_SUB,
    S_OFF_SQ,
    S_SQRT_START,
    S_SQRT,
    S_W_START,
    S_W_DIV,
    S_W_ACC,
    S_M_START,
    S_M_DIV,
    S_M_FIX,
    S_OUT
  } state_t;

endpackage

// ===== src/gidi_ram.sv =====
// ----------------------------------------------------------------------------
// gidi_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gidi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/grid_inverse_distance_interp.sv =====
// ----------------------------------------------------------------------------
// grid_inverse_distance_interp
// 3D grid of three-component corners in RAM; a query returns the inverse
// distance weighted mean of the 8 corners of the enclosing cell.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  req_type, load_*, query_*
//  out_     output     out_valid/out_stall mean_*, clamped
//  cfg_     input      cfg_we             cfg_index, cfg_wdata
//
//  Loads may follow each other every cycle while no query is in progress.
//  A query runs the shared one-bit-per-cycle
//  divider (3 cell divisions, 8 weights, 3 means) and the 32-step square root.
//  Reset clears the load pointer, state and out_valid; the corner RAM is kept.
//  A result waits in the output register; the next item is taken meanwhile.
// ----------------------------------------------------------------------------
module grid_inverse_distance_interp #(
  parameter int X_CELLS = gidi_pkg::X_CELLS_DEF,
  parameter int Y_CELLS = gidi_pkg::Y_CELLS_DEF,
  parameter int Z_CELLS = gidi_pkg::Z_CELLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_req_type,
  input  logic signed [15:0]               in_load_ac,
  input  logic signed [15:0]               in_load_al,
  input  logic signed [15:0]               in_load_zc,
  input  logic signed [31:0]               in_query_x,
  input  logic signed [31:0]               in_query_y,
  input  logic signed [31:0]               in_query_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [15:0]               out_mean_ac,
  output logic signed [15:0]               out_mean_al,
  output logic signed [15:0]               out_mean_zc,
  output logic                             out_clamped,
  input  logic                             cfg_we,
  input  logic [gidi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gidi_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import gidi_pkg::*;

  localparam int CORNER_COUNT = (X_CELLS + 1) * (Y_CELLS + 1) * (Z_CELLS + 1);
  localparam int AW      = $clog2(CORNER_COUNT);
  localparam int MAXC    = (X_CELLS > Y_CELLS) ? ((X_CELLS > Z_CELLS) ? X_CELLS : Z_CELLS)
                                               : ((Y_CELLS > Z_CELLS) ? Y_CELLS : Z_CELLS);
  localparam int IDX_W   = $clog2(MAXC + 1);
  localparam int PRD_W   = IDX_W + 31;
  localparam int PW      = IDX_W + 34;
  localparam int YSTRIDE = Z_CELLS + 1;
  localparam int XSTRIDE = (Y_CELLS + 1) * (Z_CELLS + 1);

  // configuration
  logic signed [31:0] origin_r  [3];
  logic [30:0]        spacing_r [3];

  // control
  state_t     state_r, state_nxt;
  logic [1:0] ax_r, ax_nxt;
  logic       hi_r, hi_nxt;
  logic [2:0] k_r, k_nxt;
  logic [AW-1:0] lp_r;

  // datapath
  logic signed [31:0] q_r [3], q_nxt [3];
  logic               flag_r, flag_nxt;
  logic [IDX_W-1:0]   cell_r [3], cell_nxt [3];
  logic               neg_r, neg_nxt;
  logic [AW-1:0]      t_r, t_nxt, base_r, base_nxt;
  logic [PRD_W-1:0]   prod_r, prod_nxt;
  logic [30:0]        off_r, off_nxt;
  logic [61:0]        sqx_r [2], sqx_nxt [2];
  logic [61:0]        sqy_r [2], sqy_nxt [2];
  logic [61:0]        sqz_r [2], sqz_nxt [2];
  logic [32:0]        dist_r [8], dist_nxt [8];
  logic [32:0]        dmin_r, dmin_nxt;
  logic [63:0]        sv_r, sv_nxt, sres_r, sres_nxt, sbit_r, sbit_nxt;
  logic [63:0]        dvd_r, dvd_nxt, quo_r, quo_nxt;
  logic [33:0]        rem_r, rem_nxt, den_r, den_nxt;
  logic [6:0]         cnt_r, cnt_nxt;
  logic [33:0]        wsum_r, wsum_nxt;
  logic signed [49:0] num_r [3], num_nxt [3];
  logic [15:0]        mean_r [3], mean_nxt [3];

  // output register
  logic        ov_r, ov_nxt, oc_r, oc_nxt;
  logic [15:0] om_r [3], om_nxt [3];

  // combinational helpers
  logic               in_acc;
  logic [AW-1:0]      rd_addr;
  logic [CORNER_W-1:0] rd_data;
  logic [34:0]        trial, tdiff;
  logic [63:0]        ssum;
  logic               remnz;
  logic signed [33:0] cpos, cval, cells_ext;
  logic [IDX_W-1:0]   cells_sel;
  logic signed [31:0] org_sel, q_sel;
  logic [30:0]        sp_sel;
  logic signed [33:0] ldiff;
  logic [32:0]        lmag;
  logic signed [PW-1:0] coord, diff;
  logic [PW-1:0]      absd;
  logic [32:0]        dcur;
  logic [30:0]        wq;
  logic signed [47:0] wp [3];
  logic signed [49:0] numv;
  logic [49:0]        nmag, madd, qv;
  logic [IDX_W-1:0]   idx;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  assign rd_addr = base_r + (k_r[2] ? AW'(XSTRIDE) : '0) + (k_r[1] ? AW'(YSTRIDE) : '0)
                 + AW'(k_r[0]);

  gidi_ram #(
    .WIDTH(CORNER_W),
    .DEPTH(CORNER_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (in_acc && (in_req_type == REQ_LOAD)),
    .waddr(lp_r),
    .wdata({in_load_ac, in_load_al, in_load_zc}),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // configuration registers and load pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r[0]  <= X_ORIGIN_RST;
      origin_r[1]  <= Y_ORIGIN_RST;
      origin_r[2]  <= Z_ORIGIN_RST;
      spacing_r[0] <= X_SPACING_RST;
      spacing_r[1] <= Y_SPACING_RST;
      spacing_r[2] <= Z_SPACING_RST;
      lp_r         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_X_ORIGIN:  origin_r[0] <= $signed(cfg_wdata);
          CFG_Y_ORIGIN:  origin_r[1] <= $signed(cfg_wdata);
          CFG_Z_ORIGIN:  origin_r[2] <= $signed(cfg_wdata);
          CFG_X_SPACING: spacing_r[0] <= (cfg_wdata[30:0] == '0) ? 31'd1 : cfg_wdata[30:0];
          CFG_Y_SPACING: spacing_r[1] <= (cfg_wdata[30:0] == '0) ? 31'd1 : cfg_wdata[30:0];
          CFG_Z_SPACING: spacing_r[2] <= (cfg_wdata[30:0] == '0) ? 31'd1 : cfg_wdata[30:0];
          default: ;
        endcase
      end
      if (in_acc && (in_req_type == REQ_LOAD)) begin
        lp_r <= (lp_r == AW'(CORNER_COUNT - 1)) ? '0 : lp_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ax_r   <= ax_nxt;
    hi_r   <= hi_nxt;
    k_r    <= k_nxt;
    q_r    <= q_nxt;
    flag_r <= flag_nxt;
    cell_r <= cell_nxt;
    neg_r  <= neg_nxt;
    t_r    <= t_nxt;
    base_r <= base_nxt;
    prod_r <= prod_nxt;
    off_r  <= off_nxt;
    sqx_r  <= sqx_nxt;
    sqy_r  <= sqy_nxt;
    sqz_r  <= sqz_nxt;
    dist_r <= dist_nxt;
    dmin_r <= dmin_nxt;
    sv_r   <= sv_nxt;
    sres_r <= sres_nxt;
    sbit_r <= sbit_nxt;
    dvd_r  <= dvd_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    cnt_r  <= cnt_nxt;
    wsum_r <= wsum_nxt;
    num_r  <= num_nxt;
    mean_r <= mean_nxt;
    oc_r   <= oc_nxt;
    om_r   <= om_nxt;
  end

  assign out_valid   = ov_r;
  assign out_clamped = oc_r;
  assign out_mean_ac = om_r[0];
  assign out_mean_al = om_r[1];
  assign out_mean_zc = om_r[2];

  // shared datapath values
  always_comb begin
    trial = {rem_r, dvd_r[63]};
    tdiff = trial - {1'b0, den_r};
    ssum  = sres_r + sbit_r;
    remnz = (rem_r != '0);
    cpos  = {1'b0, quo_r[32:0]};
    cval  = neg_r ? (remnz ? ~cpos : -cpos) : cpos;
    unique case (ax_r)
      2'd0:    begin cells_sel = IDX_W'(X_CELLS); end
      2'd1:    begin cells_sel = IDX_W'(Y_CELLS); end
      default: begin cells_sel = IDX_W'(Z_CELLS); end
    endcase
    cells_ext = $signed({{(34 - IDX_W){1'b0}}, cells_sel});
    org_sel   = origin_r[ax_r];
    q_sel     = q_r[ax_r];
    sp_sel    = spacing_r[ax_r];
    ldiff     = $signed({{2{q_sel[31]}}, q_sel}) - $signed({{2{org_sel[31]}}, org_sel});
    lmag      = ldiff[33] ? 33'(-ldiff) : ldiff[32:0];
    idx       = cell_r[ax_r] + IDX_W'(hi_r);
    coord     = PW'(org_sel) + $signed({2'b00, prod_r});
    diff      = coord - PW'(q_sel);
    absd      = diff[PW-1] ? -diff : diff;
    dcur      = dist_r[k_r];
    wq        = quo_r[30:0];
    wp[0]     = $signed(rd_data[47:32]) * $signed({1'b0, wq});
    wp[1]     = $signed(rd_data[31:16]) * $signed({1'b0, wq});
    wp[2]     = $signed(rd_data[15:0])  * $signed({1'b0, wq});
    numv      = num_r[ax_r];
    nmag      = numv[49] ? -numv : numv;
    madd      = nmag + {17'd0, wsum_r[33:1]};
    qv        = quo_r[49:0];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    ax_nxt    = ax_r;
    hi_nxt    = hi_r;
    k_nxt     = k_r;
    q_nxt     = q_r;
    flag_nxt  = flag_r;
    cell_nxt  = cell_r;
    neg_nxt   = neg_r;
    t_nxt     = t_r;
    base_nxt  = base_r;
    prod_nxt  = prod_r;
    off_nxt   = off_r;
    sqx_nxt   = sqx_r;
    sqy_nxt   = sqy_r;
    sqz_nxt   = sqz_r;
    dist_nxt  = dist_r;
    dmin_nxt  = dmin_r;
    sv_nxt    = sv_r;
    sres_nxt  = sres_r;
    sbit_nxt  = sbit_r;
    dvd_nxt   = dvd_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    cnt_nxt   = cnt_r;
    wsum_nxt  = wsum_r;
    num_nxt   = num_r;
    mean_nxt  = mean_r;
    ov_nxt    = ov_r && out_stall;
    oc_nxt    = oc_r;
    om_nxt    = om_r;

    // one quotient bit per cycle in any divide state while its bit count is nonzero
    if ((state_r == S_LOC_DIV || state_r == S_W_DIV || state_r == S_M_DIV) && cnt_r != '0) begin
      rem_nxt = tdiff[34] ? trial[33:0] : tdiff[33:0];
      quo_nxt = {quo_r[62:0], ~tdiff[34]};
      dvd_nxt = {dvd_r[62:0], 1'b0};
      cnt_nxt = cnt_r - 7'd1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_req_type == REQ_QUERY) begin
          q_nxt[0]  = in_query_x;
          q_nxt[1]  = in_query_y;
          q_nxt[2]  = in_query_z;
          flag_nxt  = 1'b0;
          ax_nxt    = 2'd0;
          state_nxt = S_LOC_START;
        end
      end
      S_LOC_START: begin
        neg_nxt   = ldiff[33];
        dvd_nxt   = {lmag, 31'd0};
        den_nxt   = {3'd0, sp_sel};
        rem_nxt   = '0;
        quo_nxt   = '0;
        cnt_nxt   = 7'd33;
        state_nxt = S_LOC_DIV;
      end
      S_LOC_DIV: begin
        if (cnt_r == '0) state_nxt = S_LOC_FIX;
      end
      S_LOC_FIX: begin
        if (cval[33]) begin
          cell_nxt[ax_r] = '0;
          flag_nxt       = 1'b1;
        end else if (cval >= cells_ext) begin
          cell_nxt[ax_r] = cells_sel - IDX_W'(1);
          if (cval > cells_ext || remnz) flag_nxt = 1'b1;
        end else begin
          cell_nxt[ax_r] = cval[IDX_W-1:0];
        end
        if (ax_r == 2'd2) begin
          state_nxt = S_ADDR0;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = S_LOC_START;
        end
      end
      S_ADDR0: begin
        t_nxt     = AW'(cell_r[0]) * AW'(Y_CELLS + 1) + AW'(cell_r[1]);
        state_nxt = S_ADDR1;
      end
      S_ADDR1: begin
        base_nxt  = t_r * AW'(Z_CELLS + 1) + AW'(cell_r[2]);
        ax_nxt    = 2'd0;
        hi_nxt    = 1'b0;
        state_nxt = S_OFF_MUL;
      end
      S_OFF_MUL: begin
        prod_nxt  = PRD_W'(idx) * PRD_W'(sp_sel);
        state_nxt = S_OFF_SUB;
      end
      S_OFF_SUB: begin
        off_nxt   = (|absd[PW-1:31]) ? 31'h7FFF_FFFF : absd[30:0];
        state_nxt = S_OFF_SQ;
      end
      S_OFF_SQ: begin
        unique case (ax_r)
          2'd0:    begin sqx_nxt[hi_r] = off_r * off_r; end
          2'd1:    begin sqy_nxt[hi_r] = off_r * off_r; end
          default: begin sqz_nxt[hi_r] = off_r * off_r; end
        endcase
        hi_nxt = ~hi_r;
        if (hi_r) begin
          ax_nxt = ax_r + 2'd1;
          if (ax_r == 2'd2) begin
            k_nxt     = 3'd0;
            state_nxt = S_SQRT_START;
          end else begin
            state_nxt = S_OFF_MUL;
          end
        end else begin
          state_nxt = S_OFF_MUL;
        end
      end
      S_SQRT_START: begin
        sv_nxt    = 64'(sqx_r[k_r[2]]) + 64'(sqy_r[k_r[1]]) + 64'(sqz_r[k_r[0]]);
        sres_nxt  = '0;
        sbit_nxt  = 64'd1 << 62;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (sbit_r != '0) begin
          if (sv_r >= ssum) begin
            sv_nxt   = sv_r - ssum;
            sres_nxt = (sres_r >> 1) + sbit_r;
          end else begin
            sres_nxt = sres_r >> 1;
          end
          sbit_nxt = sbit_r >> 2;
        end else begin
          dist_nxt[k_r] = (sres_r == '0) ? 33'd1 : sres_r[32:0];
          if (k_r == 3'd0 || ((sres_r == '0) ? 33'd1 : sres_r[32:0]) < dmin_r) begin
            dmin_nxt = (sres_r == '0) ? 33'd1 : sres_r[32:0];
          end
          k_nxt = k_r + 3'd1;
          if (k_r == 3'd7) begin
            wsum_nxt  = '0;
            num_nxt   = '{default: '0};
            state_nxt = S_W_START;
          end else begin
            state_nxt = S_SQRT_START;
          end
        end
      end
      S_W_START: begin
        dvd_nxt   = {dmin_r, 31'd0};
        den_nxt   = {1'b0, dcur};
        rem_nxt   = '0;
        quo_nxt   = '0;
        cnt_nxt   = 7'd63;
        state_nxt = S_W_DIV;
      end
      S_W_DIV: begin
        if (cnt_r == '0) state_nxt = S_W_ACC;
      end
      S_W_ACC: begin
        wsum_nxt   = wsum_r + {3'd0, wq};
        num_nxt[0] = num_r[0] + 50'(wp[0]);
        num_nxt[1] = num_r[1] + 50'(wp[1]);
        num_nxt[2] = num_r[2] + 50'(wp[2]);
        k_nxt      = k_r + 3'd1;
        if (k_r == 3'd7) begin
          ax_nxt    = 2'd0;
          state_nxt = S_M_START;
        end else begin
          state_nxt = S_W_START;
        end
      end
      S_M_START: begin
        neg_nxt   = numv[49];
        dvd_nxt   = {madd, 14'd0};
        den_nxt   = wsum_r;
        rem_nxt   = '0;
        quo_nxt   = '0;
        cnt_nxt   = 7'd50;
        state_nxt = S_M_DIV;
      end
      S_M_DIV: begin
        if (cnt_r == '0) state_nxt = S_M_FIX;
      end
      S_M_FIX: begin
        if (neg_r) begin
          mean_nxt[ax_r] = (qv > 50'd32768) ? 16'h8000 : 16'(-qv);
        end else begin
          mean_nxt[ax_r] = (qv > 50'd32767) ? 16'h7FFF : qv[15:0];
        end
        if (ax_r == 2'd2) begin
          state_nxt = S_OUT;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = S_M_START;
        end
      end
      S_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          oc_nxt    = flag_r;
          om_nxt    = mean_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
